// ===== src/prpd_pkg.sv =====
// Shared types and constants of the palette run-length pixel decoder.
`timescale 1ns / 1ps

package prpd_pkg;

  localparam int PALETTE_DEPTH         = 256;
  localparam int PAL_IDX_W             = 8;
  localparam int COLOR_W               = 32;
  localparam int BYTE_W                = 8;
  localparam int REP_W                 = 7;
  localparam int POS_OUT_W             = 16;
  localparam int MODE_W                = 3;
  localparam int FRAME_W               = 17;
  localparam int CFG_IDX_W             = 1;
  localparam int CFG_DATA_W            = 17;
  localparam int MAX_FRAME_PIXELS_DFLT = 65536;
  localparam int JOB_QUEUE_DEPTH       = 4;

  localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_RLE127 = 3'd0,
    MODE_NIB    = 3'd1,
    MODE_CRUMB  = 3'd2,
    MODE_BIT    = 3'd3,
    MODE_BYTE   = 3'd4,
    MODE_RLE256 = 3'd5
  } mode_e;

  // What the back end does with a data byte
  typedef enum logic [2:0] {
    SHAPE_NONE,
    SHAPE_RUN,
    SHAPE_PACK4,
    SHAPE_PACK2,
    SHAPE_PACK1
  } shape_e;

  typedef struct packed {
    logic                 is_write;
    logic [PAL_IDX_W-1:0] pal_index;
    logic [COLOR_W-1:0]   color;
    logic [BYTE_W-1:0]    data;
    shape_e               shape;
    logic [REP_W-1:0]     count;
    logic                 last;
  } job_t;

endpackage

// ===== src/prpd_if.sv =====
// Valid/ready channel interfaces: input items, result items, config writes.
`timescale 1ns / 1ps

interface prpd_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [prpd_pkg::PAL_IDX_W-1:0] palette_index;
  logic [prpd_pkg::COLOR_W-1:0]   palette_color;
  logic [prpd_pkg::BYTE_W-1:0]    data_byte;
  logic                           last_byte;

  modport source (output valid, command, palette_index, palette_color, data_byte,
                  last_byte, input ready);
  modport sink (input valid, command, palette_index, palette_color, data_byte,
                last_byte, output ready);
endinterface

interface prpd_out_if;
  logic                           valid;
  logic                           ready;
  logic [prpd_pkg::COLOR_W-1:0]   color;
  logic [prpd_pkg::REP_W-1:0]     repeat_res;
  logic [prpd_pkg::POS_OUT_W-1:0] start_position;
  logic                           last_result;

  modport source (output valid, color, repeat_res, start_position, last_result,
                  input ready);
  modport sink (input valid, color, repeat_res, start_position, last_result,
                output ready);
endinterface

interface prpd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [prpd_pkg::CFG_IDX_W-1:0]  index;
  logic [prpd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/prpd_fifo.sv =====
// Short job queue between the byte parser and the pixel sequencer.
`timescale 1ns / 1ps

module prpd_fifo #(
  parameter int Depth = prpd_pkg::JOB_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  prpd_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output prpd_pkg::job_t job_o,
  output logic           empty_o
);
  import prpd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            wr_en, rd_en;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> (rd_ptr_q == wr_ptr_q))
    else $error("empty queue with unequal pointers");

  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> (rd_ptr_q == wr_ptr_q))
    else $error("full queue with unequal pointers");

endmodule

// ===== src/prpd_front.sv =====
// Byte parser: accepts items, tracks run/literal state, queues decode jobs.
`timescale 1ns / 1ps

module prpd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  prpd_in_if.sink                       in_i,
  input  logic [prpd_pkg::MODE_W-1:0]   mode_i,
  input  logic                          full_i,
  output logic                          push_o,
  output prpd_pkg::job_t                job_o
);
  import prpd_pkg::*;

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_RUN,
    PH_LIT
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [REP_W-1:0] pend_q, pend_d;
  logic [REP_W-1:0] pend_dec;
  logic [BYTE_W-1:0] b;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign b          = in_i.data_byte;
  assign pend_dec   = (pend_q != '0) ? pend_q - 1'b1 : '0;

  always_comb begin
    phase_d         = phase_q;
    pend_d          = pend_q;
    job_o.is_write  = !in_i.command;
    job_o.pal_index = in_i.palette_index;
    job_o.color     = in_i.palette_color;
    job_o.data      = b;
    job_o.shape     = SHAPE_NONE;
    job_o.count     = '0;
    job_o.last      = in_i.command && in_i.last_byte;

    if (in_i.command) begin
      case (mode_i)
        MODE_RLE127: begin
          if (phase_q != PH_CTRL) begin
            job_o.shape = SHAPE_RUN;
            job_o.count = pend_q;
            phase_d     = PH_CTRL;
            pend_d      = '0;
          end else if (!b[7]) begin
            job_o.shape = SHAPE_RUN;
            job_o.count = REP_W'(1);
          end else begin
            phase_d = PH_RUN;
            pend_d  = b[6:0];
          end
        end
        MODE_NIB:   job_o.shape = SHAPE_PACK4;
        MODE_CRUMB: job_o.shape = SHAPE_PACK2;
        MODE_BIT:   job_o.shape = SHAPE_PACK1;
        MODE_BYTE: begin
          job_o.shape = SHAPE_RUN;
          job_o.count = REP_W'(1);
        end
        MODE_RLE256: begin
          case (phase_q)
            PH_RUN: begin
              job_o.shape = SHAPE_RUN;
              job_o.count = pend_q;
              phase_d     = PH_CTRL;
              pend_d      = '0;
            end
            PH_LIT: begin
              job_o.shape = SHAPE_RUN;
              job_o.count = REP_W'(1);
              pend_d      = pend_dec;
              if (pend_dec == '0) begin
                phase_d = PH_CTRL;
              end
            end
            default: begin
              if (!b[7]) begin
                phase_d = PH_RUN;
                pend_d  = b[6:0];
              end else if (b[6:0] != '0) begin
                phase_d = PH_LIT;
                pend_d  = b[6:0];
              end else begin
                phase_d = PH_CTRL;
                pend_d  = '0;
              end
            end
          endcase
        end
        default: ;
      endcase

      if (in_i.last_byte) begin
        phase_d = PH_CTRL;
        pend_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CTRL;
      pend_q  <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
    end
  end

  a_ctrl_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CTRL) |-> (pend_q == '0))
    else $error("pending count left while expecting control byte");

  a_lit_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LIT) |-> (pend_q != '0))
    else $error("literal group with nothing pending");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && in_i.command && in_i.last_byte) |=> (phase_q == PH_CTRL))
    else $error("parser not back to control after last byte");

endmodule

// ===== src/prpd_back.sv =====
// Pixel sequencer: palette memory, per-pixel lookup, clipping, result register.
`timescale 1ns / 1ps

module prpd_back #(
  parameter int MaxFramePixels = prpd_pkg::MAX_FRAME_PIXELS_DFLT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [prpd_pkg::FRAME_W-1:0]  frame_pixels_i,
  input  logic                          q_valid_i,
  input  prpd_pkg::job_t                job_i,
  output logic                          pop_o,
  prpd_out_if.source                    out_o
);
  import prpd_pkg::*;

  localparam int PosW = $clog2(MaxFramePixels + 1);

  logic [COLOR_W-1:0]   pal_q [PALETTE_DEPTH];
  logic [COLOR_W-1:0]   rdata_q;
  logic [2:0]           k_q;
  logic                 s1_valid_q;
  logic [REP_W-1:0]     s1_cnt_q;
  logic                 s1_end_q, s1_last_q;
  logic [PosW-1:0]      pos_q, pos_d;
  logic                 out_valid_q;
  logic [COLOR_W-1:0]   out_color_q;
  logic [REP_W-1:0]     out_rep_q;
  logic [POS_OUT_W-1:0] out_start_q;
  logic                 out_last_q;

  logic                 s1_fire, s1_free, issue, last_sub, is_data;
  logic [PAL_IDX_W-1:0] idx;
  logic [REP_W-1:0]     sub_cnt, clip;
  logic [31:0]          lim32, room32, cnt32, pos32;
  logic [PosW-1:0]      lim, room;
  logic                 hit;

  // Sub-item selection for the job at the queue head
  always_comb begin
    idx      = job_i.data;
    sub_cnt  = '0;
    last_sub = 1'b1;
    case (job_i.shape)
      SHAPE_RUN: sub_cnt = job_i.count;
      SHAPE_PACK4: begin
        idx      = PAL_IDX_W'(k_q[0] ? job_i.data[3:0] : job_i.data[7:4]);
        sub_cnt  = REP_W'(1);
        last_sub = k_q[0];
      end
      SHAPE_PACK2: begin
        idx      = PAL_IDX_W'(job_i.data[{~k_q[1:0], 1'b0} +: 2]);
        sub_cnt  = REP_W'(1);
        last_sub = (k_q[1:0] == 2'd3);
      end
      SHAPE_PACK1: begin
        idx      = PAL_IDX_W'(job_i.data[~k_q]);
        sub_cnt  = REP_W'(1);
        last_sub = (k_q == 3'd7);
      end
      default: ;
    endcase
  end

  assign s1_fire = s1_valid_q && (!out_valid_q || out_o.ready);
  assign s1_free = !s1_valid_q || s1_fire;
  assign is_data = q_valid_i && !job_i.is_write;
  assign issue   = is_data && s1_free;
  assign pop_o   = (q_valid_i && job_i.is_write) || (issue && last_sub);

  // Frame clipping
  assign lim32  = (32'(frame_pixels_i) > 32'(MaxFramePixels)) ?
                  32'(MaxFramePixels) : 32'(frame_pixels_i);
  assign lim    = lim32[PosW-1:0];
  assign room   = (pos_q >= lim) ? '0 : lim - pos_q;
  assign room32 = 32'(room);
  assign cnt32  = 32'(s1_cnt_q);
  assign clip   = (cnt32 > room32) ? REP_W'(room32) : s1_cnt_q;
  assign hit    = (cnt32 >= room32);
  assign pos32  = 32'(pos_q);
  assign pos_d  = (s1_end_q && s1_last_q) ? '0 : pos_q + PosW'(clip);

  always_ff @(posedge clk_i) begin
    if (q_valid_i && job_i.is_write) begin
      pal_q[job_i.pal_index] <= job_i.color;
    end
    if (issue) begin
      rdata_q   <= pal_q[idx];
      s1_cnt_q  <= sub_cnt;
      s1_end_q  <= last_sub;
      s1_last_q <= job_i.last;
    end
    if (s1_fire && clip != '0) begin
      out_color_q <= rdata_q;
      out_rep_q   <= clip;
      out_start_q <= pos32[POS_OUT_W-1:0];
      out_last_q  <= s1_end_q || hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      s1_valid_q  <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        k_q <= last_sub ? '0 : k_q + 1'b1;
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        pos_q       <= pos_d;
        out_valid_q <= (clip != '0);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.color          = out_color_q;
  assign out_o.repeat_res     = out_rep_q;
  assign out_o.start_position = out_start_q;
  assign out_o.last_result    = out_last_q;

  a_rep_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_rep_q != '0))
    else $error("result with empty run");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos32 <= 32'(MaxFramePixels))
    else $error("pixel position beyond maximum frame");

  a_pos_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_end_q && s1_last_q) |=> (pos_q == '0))
    else $error("position not cleared after last byte");

  a_sub_in_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != '0) |-> (q_valid_i && (job_i.shape == SHAPE_PACK4 ||
                     job_i.shape == SHAPE_PACK2 || job_i.shape == SHAPE_PACK1)))
    else $error("sub-pixel counter running outside a packed byte");

endmodule

// ===== src/palette_rle_pixel_decoder_top.sv =====
// Top level of the palette run-length pixel decoder.
//
//   port    dir  payload                                                   transfer when
//   in_i    in   command, palette_index, palette_color, data_byte, last    valid & ready
//   out_o   out  color, repeat_res, start_position, last_result            valid & ready
//   cfg_i   in   index (0 decode_mode, 1 frame_pixels), data               valid & ready
//
// A palette write is applied from the queue head; a data byte takes one palette lookup
// in run and eight-bit modes, 2, 4 or 8 in the packed modes, issued in turn through
// the single read port of the palette memory. The first result of an item passes
// through the queue, the lookup register and the result register.
// The parser accepts a new item every cycle while the four-entry job queue has room.
// Reset clears parser state, position and queue, presets config; palette contents are
// kept undefined. out_o.ready low holds the result register and backs up into the queue.
`timescale 1ns / 1ps

module palette_rle_pixel_decoder_top #(
  parameter int MaxFramePixels = prpd_pkg::MAX_FRAME_PIXELS_DFLT,
  parameter int QueueDepth     = prpd_pkg::JOB_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  prpd_in_if.sink    in_i,
  prpd_out_if.source out_o,
  prpd_cfg_if.sink   cfg_i
);
  import prpd_pkg::*;

  logic [MODE_W-1:0]  mode_q;
  logic [FRAME_W-1:0] frame_q;
  logic               push, full, pop, empty;
  job_t               job_in, job_head;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RLE127;
      frame_q <= FRAME_PIXELS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_DECODE_MODE:  mode_q  <= cfg_i.data[MODE_W-1:0];
        CFG_FRAME_PIXELS: frame_q <= cfg_i.data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  prpd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .mode_i (mode_q),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  prpd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_head),
    .empty_o (empty)
  );

  prpd_back #(
    .MaxFramePixels (MaxFramePixels)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_pixels_i (frame_q),
    .q_valid_i      (!empty),
    .job_i          (job_head),
    .pop_o          (pop),
    .out_o          (out_o)
  );

endmodule
